// ===== rtl/aesm_pkg.sv =====
// ----------------------------------------------------------------------------
// aesm_pkg
// Shared codes and the command and status bundles between the encoder
// controller and its datapath.
// ----------------------------------------------------------------------------
package aesm_pkg;

  // Operation codes carried in the input tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Width of the pending counter and the follow count it feeds
  localparam int FOLLOW_BITS = 32;

  // Outcome of one renormalisation pass
  typedef enum logic [1:0] {
    RN_STOP  = 2'd0,
    RN_EMIT0 = 2'd1,
    RN_EMIT1 = 2'd2,
    RN_STRAD = 2'd3
  } rn_kind_t;

  typedef struct packed {
    logic       wr_en;      // write one table entry
    logic       rd_en;      // look up one table entry
    logic       mul_en;     // form one partial product
    logic [1:0] mul_sel;    // [1] upper bound, [0] upper half of operand
    logic       acc_en;     // fold the last partial product in
    logic [1:0] acc_sel;    // same coding as mul_sel, for the product held in mreg
    logic       div_start;  // load both dividers
    logic       div_step;   // one restoring step on both dividers
    logic       update;     // narrow the interval
    logic       pass;       // one renormalisation pass
    logic       emit_err;   // emit the zero-frequency result
    logic       finish;     // emit the closing bit and restart
  } cmd_t;

  typedef struct packed {
    logic     sym_bad;   // looked-up symbol has no frequency
    rn_kind_t kind;      // what the next pass would do
    logic     out_free;  // output register can take a result
  } sts_t;

endpackage

// ===== rtl/aesm_ctrl.sv =====
// ----------------------------------------------------------------------------
// aesm_ctrl
// Sequencer for the encoder: lookup, multiply, divide, narrow, renormalise.
// ----------------------------------------------------------------------------
module aesm_ctrl #(
  parameter int CODE_BITS = 32,
  parameter int FREQ_BITS = 30
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      in_op,
  output logic            in_ready,
  input  aesm_pkg::sts_t  sts,
  output aesm_pkg::cmd_t  cmd
);

  localparam int PW = CODE_BITS + 1 + FREQ_BITS + 1;
  localparam int CW = $clog2(PW + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOOK   = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_UPD    = 7'b0010000,
    ST_RENORM = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          emit;

  assign emit = (sts.kind == aesm_pkg::RN_EMIT0) || (sts.kind == aesm_pkg::RN_EMIT1);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            aesm_pkg::OP_LOAD:   cmd.wr_en = 1'b1;
            aesm_pkg::OP_ENCODE: begin
              cmd.rd_en  = 1'b1;
              state_next = ST_LOOK;
            end
            aesm_pkg::OP_FINISH: state_next = ST_FIN;
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        if (sts.sym_bad) begin
          if (sts.out_free) begin
            cmd.emit_err = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cnt_next   = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en  = (cnt < CW'(4));
        cmd.mul_sel = cnt[1:0];
        cmd.acc_en  = (cnt != '0);
        cmd.acc_sel = cnt[1:0] - 2'd1;
        cnt_next    = cnt + CW'(1);
        if (cnt == CW'(4)) begin
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_start = (cnt == '0);
        cmd.div_step  = (cnt != '0);
        cnt_next      = cnt + CW'(1);
        if (cnt == CW'(PW)) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        cnt_next   = '0;
        state_next = ST_RENORM;
      end
      ST_RENORM: begin
        if (sts.kind == aesm_pkg::RN_STOP) begin
          state_next = ST_IDLE;
        end else if (!emit || sts.out_free) begin
          cmd.pass = 1'b1;
          cnt_next = cnt + CW'(1);
          if (cnt == CW'(CODE_BITS - 1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== rtl/aesm_datapath.sv =====
// ----------------------------------------------------------------------------
// aesm_datapath
// Frequency tables, interval registers, shared multiplier, twin restoring
// dividers, renormalisation and the output register.
// ----------------------------------------------------------------------------
module aesm_datapath #(
  parameter int CODE_BITS = 32,
  parameter int FREQ_BITS = 30,
  parameter int SYMBOLS   = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  aesm_pkg::cmd_t                       cmd,
  output aesm_pkg::sts_t                       sts,
  input  logic [7:0]                           in_symbol,
  input  logic [FREQ_BITS-1:0]                 in_freq,
  input  logic [FREQ_BITS-1:0]                 in_cum,
  input  logic                                 cfg_we,
  input  logic [FREQ_BITS-1:0]                 cfg_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_bit,
  output logic [aesm_pkg::FOLLOW_BITS-1:0]     out_follow,
  output logic                                 out_last,
  output logic                                 out_err
);

  localparam int RW  = CODE_BITS + 1;
  localparam int CSW = FREQ_BITS + 1;
  localparam int CH  = (CSW + 1) / 2;
  localparam int MW  = RW + CH;
  localparam int PW  = RW + CSW;
  localparam int SW  = $clog2(SYMBOLS);
  localparam int FB  = aesm_pkg::FOLLOW_BITS;
  localparam logic [CODE_BITS-1:0] HALF = {1'b1, {(CODE_BITS-1){1'b0}}};
  localparam logic [CODE_BITS-1:0] QTR1 = {2'b01, {(CODE_BITS-2){1'b0}}};

  logic [FREQ_BITS-1:0] freq_mem [SYMBOLS];
  logic [FREQ_BITS-1:0] cum_mem  [SYMBOLS];
  logic [SYMBOLS-1:0]   fvalid;
  logic [FREQ_BITS-1:0] freq_rd, cum_rd;
  logic                 rd_bad;
  logic                 sym_oor;
  logic [SW-1:0]        idx;

  logic [FREQ_BITS-1:0] total;
  logic [FREQ_BITS-1:0] tot_eff;

  logic [CODE_BITS-1:0] low, high;
  logic [CODE_BITS-1:0] span;
  logic [FB-1:0]        pending, pend_inc;
  logic [RW-1:0]        range_w;
  logic [CSW-1:0]       csum_lo, csum_hi, mop;
  logic [CH-1:0]        half_op;
  logic [MW-1:0]        mreg;
  logic [PW-1:0]        acc_lo, acc_hi, shifted;
  logic [PW-1:0]        dq_lo, dq_hi;
  logic [FREQ_BITS-1:0] rem_lo, rem_hi;
  logic [FREQ_BITS:0]   trial_lo, trial_hi;
  logic                 ge_lo, ge_hi;
  logic [CODE_BITS-1:0] sub;
  aesm_pkg::rn_kind_t   kind;
  logic                 out_free;
  logic                 emit;

  assign idx     = in_symbol[SW-1:0];
  assign sym_oor = ({1'b0, in_symbol} >= 9'(SYMBOLS));
  assign tot_eff = (total == '0) ? FREQ_BITS'(1) : total;

  // Tables: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en && !sym_oor) begin
      freq_mem[idx] <= in_freq;
      cum_mem[idx]  <= in_cum;
    end
    if (cmd.rd_en) begin
      freq_rd <= freq_mem[idx];
      cum_rd  <= cum_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
      rd_bad <= 1'b0;
      total  <= FREQ_BITS'(1);
    end else begin
      if (cmd.wr_en && !sym_oor) fvalid[idx] <= 1'b1;
      if (cmd.rd_en) rd_bad <= sym_oor || !fvalid[idx];
      if (cfg_we) total <= cfg_value;
    end
  end

  // The span wraps at the code width before the one is added
  assign span    = high - low;
  assign csum_lo = CSW'(cum_rd);
  assign csum_hi = CSW'(cum_rd) + CSW'(freq_rd);
  assign range_w = {1'b0, span} + RW'(1);
  assign mop     = cmd.mul_sel[1] ? csum_hi : csum_lo;
  assign half_op = cmd.mul_sel[0] ? CH'(mop >> CH) : mop[CH-1:0];
  assign shifted = cmd.acc_sel[0] ? (PW'(mreg) << CH) : PW'(mreg);

  // Restoring division, one quotient bit per step on each bound
  assign trial_lo = {rem_lo, dq_lo[PW-1]};
  assign trial_hi = {rem_hi, dq_hi[PW-1]};
  assign ge_lo    = (trial_lo >= {1'b0, tot_eff});
  assign ge_hi    = (trial_hi >= {1'b0, tot_eff});

  always_comb begin
    if (!high[CODE_BITS-1]) begin
      kind = aesm_pkg::RN_EMIT0;
    end else if (low[CODE_BITS-1]) begin
      kind = aesm_pkg::RN_EMIT1;
    end else if (low[CODE_BITS-2] && !high[CODE_BITS-2]) begin
      kind = aesm_pkg::RN_STRAD;
    end else begin
      kind = aesm_pkg::RN_STOP;
    end
  end

  always_comb begin
    case (kind)
      aesm_pkg::RN_EMIT1: sub = HALF;
      aesm_pkg::RN_STRAD: sub = QTR1;
      default:            sub = '0;
    endcase
  end

  assign emit     = (kind == aesm_pkg::RN_EMIT0) || (kind == aesm_pkg::RN_EMIT1);
  assign pend_inc = (pending == '1) ? pending : pending + FB'(1);
  assign out_free = !out_valid || out_ready;

  assign sts.sym_bad  = rd_bad || (freq_rd == '0);
  assign sts.kind     = kind;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) mreg <= MW'(range_w) * MW'(half_op);
    if (cmd.acc_en) begin
      if (cmd.acc_sel[1]) begin
        acc_hi <= cmd.acc_sel[0] ? acc_hi + shifted : shifted;
      end else begin
        acc_lo <= cmd.acc_sel[0] ? acc_lo + shifted : shifted;
      end
    end
    if (cmd.div_start) begin
      dq_lo  <= acc_lo;
      dq_hi  <= acc_hi;
      rem_lo <= '0;
      rem_hi <= '0;
    end else if (cmd.div_step) begin
      dq_lo  <= {dq_lo[PW-2:0], ge_lo};
      dq_hi  <= {dq_hi[PW-2:0], ge_hi};
      rem_lo <= ge_lo ? FREQ_BITS'(trial_lo - {1'b0, tot_eff}) : trial_lo[FREQ_BITS-1:0];
      rem_hi <= ge_hi ? FREQ_BITS'(trial_hi - {1'b0, tot_eff}) : trial_hi[FREQ_BITS-1:0];
    end
  end

  // Interval and pending counter
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      low     <= '0;
      high    <= '1;
      pending <= '0;
    end else if (cmd.update) begin
      high <= low + dq_hi[CODE_BITS-1:0] - CODE_BITS'(1);
      low  <= low + dq_lo[CODE_BITS-1:0];
    end else if (cmd.pass) begin
      low  <= (low - sub) << 1;
      high <= ((high - sub) << 1) | CODE_BITS'(1);
      if (emit) pending <= '0;
      else      pending <= pend_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.pass && emit) || cmd.emit_err || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass && emit) begin
      out_bit    <= (kind == aesm_pkg::RN_EMIT1);
      out_follow <= pending;
      out_last   <= 1'b0;
      out_err    <= 1'b0;
    end else if (cmd.emit_err) begin
      out_bit    <= 1'b0;
      out_follow <= '0;
      out_last   <= 1'b0;
      out_err    <= 1'b1;
    end else if (cmd.finish) begin
      out_bit    <= low[CODE_BITS-1] | low[CODE_BITS-2];
      out_follow <= pend_inc;
      out_last   <= 1'b1;
      out_err    <= 1'b0;
    end
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.pass && emit) |-> out_free)
    else $error("emitting pass without a free output slot");

  a_finish_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (low == '0) && (high == '1) && (pending == '0))
    else $error("interval not restarted after finish");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_err |=> out_valid && out_err && !out_last)
    else $error("zero-frequency result not presented");

endmodule

// ===== rtl/arithmetic_encoder_static_model.sv =====
// ----------------------------------------------------------------------------
// arithmetic_encoder_static_model
// Binary arithmetic encoder over a static per-symbol frequency table.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: writes total_count (the interval divisor); write only while
//   idle. cfg_ready is always high.
//   s channel: tuser holds op (load, encode, finish); tdata holds symbol,
//   frequency and cumulative start. A load writes one table entry; an encode
//   narrows the interval and emits zero or more code bits; a finish emits the
//   closing bit with tlast high.
//   m channel: each transaction is one code bit plus the count of opposite
//   bits that follow it; tuser flags an encode of a zero-frequency symbol.
// Sequence:
//   a load is written as it is taken. A finish waits for a free output slot.
//   An encode runs lookup, multiply, divide, narrow, then at most CODE_BITS
//   renormalisation passes; a run of CODE_BITS passes skips the final
//   check. The restoring dividers work one quotient bit a cycle over the
//   full product.
//   One item is worked on at a time; the next is taken once it is done.
// Reset clears the interval and the pending count, marks every table entry
// unloaded and sets total_count to 1. A stalled receiver holds the output
// transaction and halts the renormalisation at the next bit to emit.
// ----------------------------------------------------------------------------
module arithmetic_encoder_static_model #(
  parameter int CODE_BITS = 32,
  parameter int FREQ_BITS = 30,
  parameter int SYMBOLS   = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write: total_count
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [FREQ_BITS-1:0]        cfg_data,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // tdata from bit 0: symbol[7:0], frequency, cumulative start, zero fill
  input  logic [((8+2*FREQ_BITS+7)/8)*8-1:0] s_tdata,
  // tuser: op[1:0]
  input  logic [1:0]                  s_tuser,
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // tdata from bit 0: first_bit, follow_count[31:0], zero fill
  output logic [39:0]                 m_tdata,
  // tuser: error
  output logic                        m_tuser,
  output logic                        m_tlast
);

  aesm_pkg::cmd_t cmd;
  aesm_pkg::sts_t sts;
  logic           out_bit;
  logic [aesm_pkg::FOLLOW_BITS-1:0] out_follow;

  // The register port never stalls
  assign cfg_ready = 1'b1;

  aesm_ctrl #(
    .CODE_BITS (CODE_BITS),
    .FREQ_BITS (FREQ_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aesm_datapath #(
    .CODE_BITS (CODE_BITS),
    .FREQ_BITS (FREQ_BITS),
    .SYMBOLS   (SYMBOLS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_symbol  (s_tdata[7:0]),
    .in_freq    (s_tdata[8 +: FREQ_BITS]),
    .in_cum     (s_tdata[8+FREQ_BITS +: FREQ_BITS]),
    .cfg_we     (cfg_valid),
    .cfg_value  (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_bit    (out_bit),
    .out_follow (out_follow),
    .out_last   (m_tlast),
    .out_err    (m_tuser)
  );

  // Pack the result, padding to whole bytes
  assign m_tdata = {7'd0, out_follow, out_bit};

endmodule

// ===== tb/tb_arithmetic_encoder_static_model.sv =====
// ----------------------------------------------------------------------------
// Arithmetic encoder testbench
// Drives load, encode, finish and unused-op transactions with random gaps,
// predicts the emitted code bits with a behavioural encoder and checks every
// output transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_arithmetic_encoder_static_model;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 32;
  localparam int FB = 30;
  localparam int SYMS = 256;
  localparam int SW = ((8 + 2 * FB + 7) / 8) * 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] HALF = 64'h8000_0000;
  localparam logic [63:0] QTR1 = 64'h4000_0000;
  localparam logic [63:0] QTR3 = 64'hC000_0000;
  localparam logic [63:0] CMASK = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] sym;
    logic [FB-1:0] freq;
    logic [FB-1:0] cum;
  } item_t;

  typedef struct packed {
    logic bit0;
    logic [31:0] follow;
    logic last;
    logic err;
  } code_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [FB-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [39:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  arithmetic_encoder_static_model dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  // Encoder state mirrored in the testbench
  logic [63:0] enc_low, enc_high;
  logic [31:0] enc_pending;
  logic [FB-1:0] freq_tab [SYMS];
  logic [FB-1:0] cum_tab [SYMS];
  logic [FB-1:0] enc_total;

  item_t pending_items[$];
  code_t expected_codes[$];
  int failures = 0;
  bit hold_send = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void bump_pending();
    if (enc_pending != 32'hFFFF_FFFF) enc_pending++;
  endfunction

  // Work out the code bits that one accepted transaction causes
  task automatic encode_item(input item_t it);
    logic [63:0] f, c, t, rng, hoff, loff;
    code_t r;
    case (it.op)
      aesm_pkg::OP_LOAD: begin
        freq_tab[it.sym] = it.freq;
        cum_tab[it.sym] = it.cum;
      end
      aesm_pkg::OP_ENCODE: begin
        if (freq_tab[it.sym] == 0) begin
          r = '0;
          r.err = 1;
          expected_codes.push_back(r);
        end else begin
          f = freq_tab[it.sym];
          c = cum_tab[it.sym];
          t = (enc_total == 0) ? 64'd1 : 64'(enc_total);
          rng = ((enc_high - enc_low) & CMASK) + 1;
          hoff = ((rng * (c + f)) / t) & CMASK;
          loff = ((rng * c) / t) & CMASK;
          enc_high = (enc_low + hoff - 1) & CMASK;
          enc_low = (enc_low + loff) & CMASK;
          for (int p = 0; p < CB; p++) begin
            r = '0;
            if (enc_high < HALF) begin
              r.follow = enc_pending;
              expected_codes.push_back(r);
              enc_pending = 0;
            end else if (enc_low >= HALF) begin
              r.bit0 = 1;
              r.follow = enc_pending;
              expected_codes.push_back(r);
              enc_pending = 0;
              enc_low -= HALF;
              enc_high -= HALF;
            end else if (enc_low >= QTR1 && enc_high < QTR3) begin
              bump_pending();
              enc_low -= QTR1;
              enc_high -= QTR1;
            end else begin
              break;
            end
            enc_low = (enc_low << 1) & CMASK;
            enc_high = ((enc_high << 1) + 1) & CMASK;
          end
        end
      end
      aesm_pkg::OP_FINISH: begin
        bump_pending();
        r = '0;
        r.bit0 = (enc_low >= QTR1);
        r.follow = enc_pending;
        r.last = 1;
        expected_codes.push_back(r);
        enc_low = 0;
        enc_high = CMASK;
        enc_pending = 0;
      end
      default: ;
    endcase
  endtask

  // Driver: present queued transactions, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (s_tvalid && s_tready) begin
      encode_item(pending_items.pop_front());
      send_gap = pick_gap();
      s_tvalid <= 0;
    end else if (!s_tvalid && !hold_send && pending_items.size() > 0) begin
      if (send_gap > 0) begin
        send_gap--;
      end else begin
        s_tvalid <= 1;
        s_tuser <= pending_items[0].op;
        s_tdata <= SW'({pending_items[0].cum, pending_items[0].freq, pending_items[0].sym});
      end
    end
  end

  // Monitor: random back-pressure, compare with the oldest expectation
  always @(posedge clk) begin
    code_t exp_r, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{bit0: m_tdata[0], follow: m_tdata[32:1], last: m_tlast, err: m_tuser};
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, got);
          failures++;
        end else begin
          exp_r = expected_codes.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
            failures++;
          end
        end
        recv_gap = pick_gap();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Wait for the block to drain, then for its worst-case tail
  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_codes.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_total(input logic [FB-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    enc_total = v;
  endtask

  function automatic void queue_item(logic [1:0] op, logic [7:0] s, logic [FB-1:0] f,
                                     logic [FB-1:0] c);
    item_t it;
    it = '{op: op, sym: s, freq: f, cum: c};
    pending_items.push_back(it);
  endfunction

  // Load a table that is consistent with total t and encode a random message
  task automatic random_phase(input logic [FB-1:0] t, input int n);
    logic [FB-1:0] acc, f;
    int nsym, r;
    nsym = $urandom_range(2, 12);
    write_total(t);
    acc = 0;
    for (int k = 0; k < nsym; k++) begin
      f = (k == nsym - 1) ? t - acc : FB'($urandom_range(0, 32'(t - acc)));
      if (t - acc == 0) f = 0;
      queue_item(aesm_pkg::OP_LOAD, 8'(k * 23 + 1), f, acc);
      acc += f;
    end
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        queue_item(aesm_pkg::OP_ENCODE, 8'(($urandom_range(0, nsym - 1)) * 23 + 1),
                   '0, '0);
      else if (r < 88)
        queue_item(aesm_pkg::OP_ENCODE, 8'($urandom), FB'($urandom), FB'($urandom));
      else if (r < 94) queue_item(aesm_pkg::OP_FINISH, 8'($urandom), '0, '0);
      else if (r < 97) queue_item(OP_UNUSED, 8'($urandom), FB'($urandom), FB'($urandom));
      else queue_item(aesm_pkg::OP_LOAD, 8'($urandom), FB'($urandom), FB'($urandom));
    end
    queue_item(aesm_pkg::OP_FINISH, 8'h00, '0, '0);
  endtask

  initial begin
    enc_low = 0;
    enc_high = CMASK;
    enc_pending = 0;
    enc_total = 1;
    foreach (freq_tab[i]) begin
      freq_tab[i] = 0;
      cum_tab[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset total of one, extremes of each field, every op
    queue_item(aesm_pkg::OP_ENCODE, 8'h00, '0, '0);       // zero frequency
    queue_item(aesm_pkg::OP_LOAD, 8'hFF, FB'(1), '0);
    queue_item(aesm_pkg::OP_ENCODE, 8'hFF, '0, '0);       // whole interval
    queue_item(aesm_pkg::OP_FINISH, 8'h00, '0, '0);
    queue_item(OP_UNUSED, 8'hAA, '1, '1);                 // ignored
    write_total('1);
    queue_item(aesm_pkg::OP_LOAD, 8'h00, FB'(1), '0);     // tiny slice, long renorm
    queue_item(aesm_pkg::OP_LOAD, 8'h80, '1, '1);         // wraps the interval
    queue_item(aesm_pkg::OP_LOAD, 8'h55, FB'(30'h2000_0000), FB'(30'h1000_0000));
    queue_item(aesm_pkg::OP_ENCODE, 8'h00, '0, '0);
    queue_item(aesm_pkg::OP_ENCODE, 8'h80, '0, '0);
    queue_item(aesm_pkg::OP_ENCODE, 8'h55, '0, '0);       // straddle
    queue_item(aesm_pkg::OP_ENCODE, 8'h55, '0, '0);
    queue_item(aesm_pkg::OP_ENCODE, 8'h7F, '0, '0);
    queue_item(aesm_pkg::OP_FINISH, 8'hFF, '1, '1);
    write_total('0);                                      // zero used as one
    queue_item(aesm_pkg::OP_ENCODE, 8'h00, '0, '0);
    queue_item(aesm_pkg::OP_FINISH, 8'h00, '0, '0);

    // Random phases with a range of totals
    random_phase(FB'(16), 60);
    random_phase(FB'($urandom_range(2, 1000)), 80);
    // Once every result is in, hold the sender with an item queued
    drain();
    hold_send = 1;
    queue_item(aesm_pkg::OP_ENCODE, 8'h01, '0, '0);
    repeat (50) @(posedge clk);
    hold_send = 0;
    random_phase(FB'($urandom), 80);
    random_phase('1, 80);
    random_phase(FB'(3), 60);
    drain();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aesm_pkg.sv
rtl/aesm_ctrl.sv
rtl/aesm_datapath.sv
rtl/arithmetic_encoder_static_model.sv
tb/tb_arithmetic_encoder_static_model.sv
